### rtl/core/sfsu_pkg.sv
// Starfield star update: shared constants, types and the hash mix function.
// No dependencies.
`default_nettype none
package sfsu_pkg;
   localparam int unsigned STAR_COUNT    = 64;
   localparam int unsigned IDX_W         = 6;
   localparam int unsigned SCREEN_WIDTH  = 160;
   localparam int unsigned SCREEN_HEIGHT = 80;
   localparam logic [31:0] HASH_B        = 32'h72837482;
   localparam logic [31:0] HASH_C        = 32'hdeadbeef;
   localparam logic [14:0] FAR_DEPTH     = 15'h7fff;
   localparam logic [4:0]  BRIGHT_MAX    = 5'd31;
   localparam logic [14:0] DELTA_RESET   = 15'd10;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [14:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int k);
      rotl32 = (v << k) | (v >> (32 - k));
   endfunction

   function automatic logic [31:0] mix3(input logic [31:0] a_in);
      logic [31:0] a, b, c;
      a = a_in; b = HASH_B; c = HASH_C;
      a = a - c; a = a ^ rotl32(c, 4);  c = c + b;
      b = b - a; b = b ^ rotl32(a, 6);  a = a + c;
      c = c - b; c = c ^ rotl32(b, 8);  b = b + a;
      a = a - c; a = a ^ rotl32(c, 16); c = c + b;
      b = b - a; b = b ^ rotl32(a, 19); a = a + c;
      c = c - b; c = c ^ rotl32(b, 4);
      mix3 = c;
   endfunction
endpackage
`default_nettype wire

### rtl/core/sfsu_divider.sv
// Starfield star update: unsigned 32/15 restoring divider, one bit a cycle.
// Depends on sfsu_pkg.
`default_nettype none
module sfsu_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sfsu_pkg::div_req_type div_req,
   output      sfsu_pkg::div_rsp_type div_rsp
);
   import sfsu_pkg::*;

   logic [31:0] quot_ff, quot_in;
   logic [15:0] rem_ff, rem_in;
   logic [14:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [15:0] trial;
   logic [16:0] diff;

   always_comb begin
      quot_in = quot_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[14:0], quot_ff[31]};
      diff = {1'b0, trial} - {2'b00, dvs_ff};
      if (div_req.start) begin
         quot_in = div_req.dividend; rem_in = '0; dvs_in = div_req.divisor;
         cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_in = diff[15:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quot_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> busy_ff && cnt_ff == 6'd32)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 6'd0)
      else $error("divider count underflow");
endmodule
`default_nettype wire

### rtl/core/starfield_star_update.sv
// Starfield star update top level: each request updates one star and yields an erase
// point, a draw point, both or neither. When the star respawns it also runs two hashes
// of six mixing rounds each, one round a cycle. Every request makes two passes through
// one shared bit-serial divider, and result stalls can hold a request up. A new request is
// taken only once the previous one is done. The star table lives in flip-flops with
// per-star valid bits, so no clearing pass follows reset. Delta is written through
// the csr_ port while idle.
`default_nettype none
module starfield_star_update (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [5:0]  req_star_index,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_pixel_x,
   output      logic [6:0]  rsp_pixel_y,
   output      logic [15:0] rsp_color,
   output      logic        rsp_is_erase,
   output      logic        rsp_last,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [14:0] csr_delta
);
   import sfsu_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_READ  = 10'b0000000010,
      S_DEPTH = 10'b0000000100,
      S_SEED  = 10'b0000001000,
      S_DIVX  = 10'b0000010000,
      S_WAITX = 10'b0000100000,
      S_WAITY = 10'b0001000000,
      S_DRAW  = 10'b0010000000,
      S_ERASE = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] seed_x_ff [STAR_COUNT];
   logic [15:0] seed_y_ff [STAR_COUNT];
   logic [14:0] depth_ff  [STAR_COUNT];
   logic [7:0]  posx_ff   [STAR_COUNT];
   logic [6:0]  posy_ff   [STAR_COUNT];
   logic [STAR_COUNT-1:0] vis_ff, written_ff;

   logic [31:0] rng_ff;
   logic [14:0] delta_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [15:0] sx_ff, sy_ff;
   logic [14:0] z_ff;
   logic [7:0]  ox_ff;
   logic [6:0]  oy_ff;
   logic        ovis_ff;
   logic        xneg_ff, yneg_ff;
   logic [31:0] qx_ff;
   logic        erase_pend_ff;
   logic        seed_hi_ff;
   logic [31:0] hx_ff, hy_ff, hz_ff;
   logic [2:0]  hrnd_ff;

   logic        rv_ff;
   logic [7:0]  rx_ff;
   logic [6:0]  ry_ff;
   logic [15:0] rc_ff;
   logic        re_ff, rl_ff;

   logic        draw_ok_ff;
   logic [7:0]  npx_ff;
   logic [6:0]  npy_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   sfsu_divider u_div (.clock(clock), .reset(reset), .div_req(dreq), .div_rsp(drsp));

   // read view of an entry (unwritten entries read as reset value)
   logic [IDX_W-1:0] ridx;
   logic             rw, rvis;
   assign ridx = req_star_index;
   assign rw   = written_ff[idx_ff];
   assign rvis = vis_ff[idx_ff];

   // z_ff holds the stored depth here
   logic signed [16:0] znew;
   assign znew = $signed({2'b00, z_ff}) - $signed({2'b00, delta_ff});

   // one mixing round a cycle; (hx, hy, hz) rotate roles after each round
   logic [31:0] hrot, hmix, hsum;
   logic        hash_done;
   assign hash_done = (hrnd_ff == 3'd6);

   always_comb begin
      case (hrnd_ff)
         3'd0:    hrot = rotl32(hz_ff, 4);
         3'd1:    hrot = rotl32(hz_ff, 6);
         3'd2:    hrot = rotl32(hz_ff, 8);
         3'd3:    hrot = rotl32(hz_ff, 16);
         3'd4:    hrot = rotl32(hz_ff, 19);
         default: hrot = rotl32(hz_ff, 4);
      endcase
   end

   assign hmix = (hx_ff - hz_ff) ^ hrot;
   assign hsum = hz_ff + hy_ff;

   // projection helpers
   function automatic logic signed [31:0] fl10(input logic neg, input logic [31:0] q);
      logic [31:0] t;
      t = neg ? (q + 32'd1023) >> 10 : q >> 10;
      fl10 = neg ? -$signed(t) : $signed(t);
   endfunction

   logic [15:0] absx, absy;
   assign absx = sx_ff[15] ? 16'(-sx_ff) : sx_ff;
   assign absy = sy_ff[15] ? 16'(-sy_ff) : sy_ff;

   logic signed [31:0] px, py;
   assign px = fl10(xneg_ff, qx_ff) + $signed(32'(SCREEN_WIDTH / 2));
   assign py = fl10(yneg_ff, drsp.quotient) + $signed(32'(SCREEN_HEIGHT / 2));
   logic onscr;
   assign onscr = !px[31] && px < $signed(32'(SCREEN_WIDTH)) &&
                  !py[31] && py < $signed(32'(SCREEN_HEIGHT));

   logic [14:0] far_minus;
   logic [5:0]  gsh;
   logic [4:0]  gv;
   assign far_minus = FAR_DEPTH - z_ff;
   assign gsh = far_minus[14:9];
   assign gv = (gsh > {1'b0, BRIGHT_MAX}) ? BRIGHT_MAX : gsh[4:0];

   logic signed [8:0] dx;
   logic signed [8:0] dy;
   logic [17:0] bgsum;
   assign dx = $signed({1'b0, ox_ff}) - $signed(9'(SCREEN_WIDTH / 2));
   assign dy = ($signed({2'b00, oy_ff}) - $signed(9'(SCREEN_HEIGHT / 2))) <<< 1;
   assign bgsum = 18'(dx * dx) + 18'(dy * dy);

   logic out_free;
   assign out_free = !rv_ff || !rsp_stall;

   logic ld_erase, ld_draw;
   assign ld_erase = (state_ff == S_ERASE) && ovis_ff && out_free;
   assign ld_draw  = (state_ff == S_OUT) && draw_ok_ff && out_free;

   always_comb begin
      state_in = state_ff;
      dreq.start = 1'b0;
      dreq.dividend = '0;
      dreq.divisor = z_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_READ;
         S_READ:  state_in = S_DEPTH;
         S_DEPTH: state_in = S_SEED;
         S_SEED:  if (!erase_pend_ff || (hash_done && seed_hi_ff)) state_in = S_DIVX;
         S_DIVX: begin
            dreq.start = 1'b1;
            dreq.dividend = {absx, 16'h0};
            state_in = S_WAITX;
         end
         S_WAITX: if (drsp.done) begin
            dreq.start = 1'b1;
            dreq.dividend = {absy, 16'h0};
            state_in = S_WAITY;
         end
         S_WAITY: if (drsp.done) state_in = S_DRAW;
         S_DRAW:  state_in = S_ERASE;
         S_ERASE: if (out_free || !ovis_ff) state_in = S_OUT;
         S_OUT:   if (out_free || !draw_ok_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vis_ff <= '1;
         written_ff <= '0;
         rng_ff <= '0;
         delta_ff <= DELTA_RESET;
         rv_ff <= 1'b0;
         erase_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) delta_ff <= csr_delta;
         if (ld_erase || ld_draw) rv_ff <= 1'b1;
         else if (!rsp_stall) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_valid) idx_ff <= ridx;
            S_READ: begin
               ovis_ff <= rvis;
               ox_ff <= rw ? posx_ff[idx_ff] : 8'd0;
               oy_ff <= rw ? posy_ff[idx_ff] : 7'd0;
               sx_ff <= rw ? seed_x_ff[idx_ff] : 16'd0;
               sy_ff <= rw ? seed_y_ff[idx_ff] : 16'd0;
               z_ff <= rw ? depth_ff[idx_ff] : 15'd0;
            end
            S_DEPTH: begin
               erase_pend_ff <= (znew <= 17'sd0) || !ovis_ff;
               z_ff <= znew[14:0];
               seed_hi_ff <= 1'b0;
               hx_ff <= rng_ff; hy_ff <= HASH_B; hz_ff <= HASH_C;
               hrnd_ff <= 3'd0;
            end
            S_SEED: if (erase_pend_ff) begin
               // respawn takes two hashes: x seed first, then y seed
               if (!hash_done) begin
                  hx_ff <= hy_ff; hy_ff <= hsum; hz_ff <= hmix;
                  hrnd_ff <= hrnd_ff + 3'd1;
               end else if (!seed_hi_ff) begin
                  sx_ff <= hz_ff[15:0];
                  seed_hi_ff <= 1'b1;
                  rng_ff <= rng_ff + 32'd1;
                  hx_ff <= rng_ff + 32'd1; hy_ff <= HASH_B; hz_ff <= HASH_C;
                  hrnd_ff <= 3'd0;
               end else begin
                  sy_ff <= hz_ff[15:0];
                  rng_ff <= rng_ff + 32'd1;
                  z_ff <= FAR_DEPTH;
                  erase_pend_ff <= 1'b0;
               end
            end
            S_DIVX: begin
               xneg_ff <= sx_ff[15];
               yneg_ff <= sy_ff[15];
            end
            S_WAITX: if (drsp.done) qx_ff <= drsp.quotient;
            S_WAITY: if (drsp.done) begin
               draw_ok_ff <= onscr;
               npx_ff <= px[7:0];
               npy_ff <= py[6:0];
            end
            S_DRAW: begin
               seed_x_ff[idx_ff] <= sx_ff;
               seed_y_ff[idx_ff] <= sy_ff;
               depth_ff[idx_ff] <= z_ff;
               written_ff[idx_ff] <= 1'b1;
               vis_ff[idx_ff] <= draw_ok_ff;
               if (draw_ok_ff) begin
                  posx_ff[idx_ff] <= npx_ff;
                  posy_ff[idx_ff] <= npy_ff;
               end else if (!rw) begin
                  posx_ff[idx_ff] <= 8'd0;
                  posy_ff[idx_ff] <= 7'd0;
               end
            end
            S_ERASE: if (ld_erase) begin
               // erase is last when no draw point follows
               rx_ff <= ox_ff; ry_ff <= oy_ff;
               rc_ff <= 16'(bgsum >> 11);
               re_ff <= 1'b1; rl_ff <= !draw_ok_ff;
            end
            S_OUT: if (ld_draw) begin
               rx_ff <= npx_ff; ry_ff <= npy_ff;
               rc_ff <= {1'b0, gv[4:1], 1'b0, gv, 1'b0, gv[4:1]};
               re_ff <= 1'b0; rl_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid    = rv_ff;
   assign rsp_pixel_x  = rx_ff;
   assign rsp_pixel_y  = ry_ff;
   assign rsp_color    = rc_ff;
   assign rsp_is_erase = re_ff;
   assign rsp_last     = rl_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !csr_ready)
      else $error("csr ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_READ)
      else $error("request not taken");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAITY && drsp.done) |=> state_ff == S_DRAW)
      else $error("sequencer skipped draw");
endmodule
`default_nettype wire

### test/testbench.sv
// Testbench for starfield_star_update: random and directed star updates,
// checked against an in-bench model of the star table. Depends on sfsu_pkg.
`timescale 1ns / 100ps
module testbench;
   import sfsu_pkg::*;

   typedef struct packed {
      logic [7:0]  px;
      logic [6:0]  py;
      logic [15:0] color;
      logic        erase;
      logic        last;
   } point_type;

   class point_scoreboard;
      logic [15:0] sx[STAR_COUNT], sy[STAR_COUNT];
      logic [14:0] dz[STAR_COUNT];
      logic [7:0]  ox[STAR_COUNT];
      logic [6:0]  oy[STAR_COUNT];
      bit          vis[STAR_COUNT];
      logic [31:0] counter;
      logic [14:0] delta;
      point_type   pending_points[$];
      int          errors;

      function new();
         for (int i = 0; i < STAR_COUNT; i++) begin
            sx[i] = 0; sy[i] = 0; dz[i] = 0; ox[i] = 0; oy[i] = 0; vis[i] = 1;
         end
         counter = 0; delta = DELTA_RESET; errors = 0;
      endfunction

      function logic [15:0] hash_seed();
         logic [31:0] a, b, c;
         a = counter; b = HASH_B; c = HASH_C;
         a = a - c; a = a ^ {c[27:0], c[31:28]};  c = c + b;
         b = b - a; b = b ^ {a[25:0], a[31:26]};  a = a + c;
         c = c - b; c = c ^ {b[23:0], b[31:24]};  b = b + a;
         a = a - c; a = a ^ {c[15:0], c[31:16]};  c = c + b;
         b = b - a; b = b ^ {a[12:0], a[31:13]};  a = a + c;
         c = c - b; c = c ^ {b[27:0], b[31:28]};
         counter = counter + 1;
         return c[15:0];
      endfunction

      // truncating divide, then floor shift
      function longint project_axis(logic [15:0] seed, int z);
         longint q;
         q = (longint'($signed(seed)) * 65536) / z;
         return q >>> 10;
      endfunction

      function void note_request(logic [5:0] idx);
         int dx, dy, z, g, r;
         longint px, py;
         point_type p;
         int n0;
         n0 = pending_points.size();
         if (vis[idx]) begin
            dx = int'(ox[idx]) - SCREEN_WIDTH / 2;
            dy = (int'(oy[idx]) - SCREEN_HEIGHT / 2) * 2;
            p.px = ox[idx]; p.py = oy[idx];
            p.color = 16'((dx * dx + dy * dy) >> 11);
            p.erase = 1; p.last = 0;
            pending_points.push_back(p);
         end
         z = int'(dz[idx]) - int'(delta);
         if (z <= 0 || !vis[idx]) begin
            sx[idx] = hash_seed();
            sy[idx] = hash_seed();
            z = FAR_DEPTH;
         end
         dz[idx] = 15'(z);
         px = project_axis(sx[idx], z) + SCREEN_WIDTH / 2;
         py = project_axis(sy[idx], z) + SCREEN_HEIGHT / 2;
         if (px < 0 || px >= SCREEN_WIDTH || py < 0 || py >= SCREEN_HEIGHT) begin
            vis[idx] = 0;
         end else begin
            g = (FAR_DEPTH - z) >> 9;
            if (g > BRIGHT_MAX) g = BRIGHT_MAX;
            r = g >> 1;
            vis[idx] = 1; ox[idx] = 8'(px); oy[idx] = 7'(py);
            p.px = 8'(px); p.py = 7'(py);
            p.color = 16'((r << 11) | (g << 5) | r);
            p.erase = 0; p.last = 0;
            pending_points.push_back(p);
         end
         if (pending_points.size() > n0)
            pending_points[pending_points.size() - 1].last = 1;
      endfunction

      function void check_point(point_type got);
         point_type e;
         if (pending_points.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d", $time, got.px, got.py);
            errors++;
            return;
         end
         e = pending_points.pop_front();
         if (got.px !== e.px)
            $display("%0t: pixel_x expected %0d actual %0d", $time, e.px, got.px);
         if (got.py !== e.py)
            $display("%0t: pixel_y expected %0d actual %0d", $time, e.py, got.py);
         if (got.color !== e.color)
            $display("%0t: color expected %h actual %h", $time, e.color, got.color);
         if (got.erase !== e.erase)
            $display("%0t: is_erase expected %b actual %b", $time, e.erase, got.erase);
         if (got.last !== e.last)
            $display("%0t: last expected %b actual %b", $time, e.last, got.last);
         if (got !== e) errors++;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [5:0]  req_star_index = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [7:0]  rsp_pixel_x;
   logic [6:0]  rsp_pixel_y;
   logic [15:0] rsp_color;
   logic        rsp_is_erase;
   logic        rsp_last;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [14:0] csr_delta = 0;

   point_scoreboard board = new();
   bit  quiet_tail = 0;
   int  idle_cycles = 0;
   localparam int WATCHDOG_LIMIT = 20000;

   starfield_star_update dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // response side: random stall bursts, checked on accept
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_point({rsp_pixel_x, rsp_pixel_y, rsp_color, rsp_is_erase, rsp_last});
   end

   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 7);
            rsp_stall <= 1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // valid stays high after an accept; drain() takes it down, and the next request may drop it for a random gap
   task automatic send_star(input logic [5:0] idx);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1;
      req_star_index <= idx;
      do @(posedge clock); while (req_stall);
      board.note_request(idx);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending_points.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_delta(input logic [14:0] value);
      drain();
      csr_valid <= 1;
      csr_delta <= value;
      do @(posedge clock); while (!csr_ready);
      board.delta = value;
      csr_valid <= 0;
   endtask

   initial begin
      logic [14:0] deltas[6];
      deltas = '{15'd10, 15'd1, 15'd32767, 15'd300, 15'd2000, 15'd16384};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: first touch of stars at pixel zero, both index ends
      send_star(0); send_star(63); send_star(0); send_star(63);
      for (int i = 1; i < 10; i++) send_star(6'(i * 7));
      send_star(0); send_star(0);
      write_delta(15'd32767);
      send_star(0); send_star(63); send_star(5); send_star(5);
      write_delta(15'd1);
      send_star(63); send_star(63); send_star(0); send_star(21);
      for (int ph = 0; ph < 6; ph++) begin
         write_delta(ph == 5 ? 15'($urandom_range(1, 32767)) : deltas[ph]);
         for (int k = 0; k < 100; k++) begin
            if (ph == 5 && k == 50) quiet_tail = 1;
            // mostly a small working set so stars travel deep before respawn
            send_star($urandom_range(0, 3) == 0 ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 7)));
         end
      end
      drain();
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

### files.f
rtl/core/sfsu_pkg.sv
rtl/core/sfsu_divider.sv
rtl/core/starfield_star_update.sv
test/testbench.sv
